// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the bank mapper checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define BMSIRQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("bmsirq assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define BMSIRQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("bmsirq assertion failed");

`endif

// ===== design/bmsirq_pkg.sv =====
// ----------------------------------------------------------------------------
// bmsirq_pkg
// Types, codes and constants shared by the bank mapper modules.
// ----------------------------------------------------------------------------
`default_nettype none

package bmsirq_pkg;

	localparam logic [8:0] PRG_BANKS_MAX = 9'd64;
	localparam logic [8:0] CHR_BANKS_MAX = 9'd256;

	// access kinds
	localparam logic [1:0] OP_CPU_RD = 2'd0;
	localparam logic [1:0] OP_CPU_WR = 2'd1;
	localparam logic [1:0] OP_PPU_RD = 2'd2;
	localparam logic [1:0] OP_PPU_WR = 2'd3;

	// result targets
	localparam logic [1:0] TGT_NONE    = 2'd0;
	localparam logic [1:0] TGT_PRG_RAM = 2'd1;
	localparam logic [1:0] TGT_PRG_ROM = 2'd2;
	localparam logic [1:0] TGT_CHR     = 2'd3;

	// mirroring modes
	localparam logic [1:0] MIR_VERT = 2'd0;
	localparam logic [1:0] MIR_HORZ = 2'd1;
	localparam logic [1:0] MIR_FOUR = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_PRG_COUNT = 2'd0;
	localparam logic [1:0] CFG_CHR_COUNT = 2'd1;
	localparam logic [1:0] CFG_CHR_RAM   = 2'd2;
	localparam logic [1:0] CFG_INIT_MIR  = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       start;
		logic [7:0] dividend;
		logic [8:0] divisor;
	} div_cmd_t;

	typedef struct packed {
		logic       busy;
		logic       done;
		logic [7:0] rem;
	} div_stat_t;

endpackage

`default_nettype wire

// ===== design/bmsirq_mod.sv =====
// ----------------------------------------------------------------------------
// bmsirq_mod
// Restoring remainder unit: 8-bit dividend by 9-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bmsirq_mod (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire bmsirq_pkg::div_cmd_t cmd,
	output bmsirq_pkg::div_stat_t stat
);

	logic       busy_q;
	logic       done_q;
	logic [2:0] cnt_q;
	logic [7:0] quo_q;
	logic [7:0] rem_q;
	logic [8:0] div_q;
	logic [8:0] trial;

	assign trial = {rem_q, quo_q[7]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			quo_q <= cmd.dividend;
			rem_q <= '0;
			div_q <= cmd.divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[6:0], 1'b0};
			// remainder stays below the divisor, so it fits 8 bits
			if (trial >= div_q) rem_q <= 8'(trial - div_q);
			else rem_q <= trial[7:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign stat.rem  = rem_q;

endmodule

`default_nettype wire

// ===== design/bank_mapper_with_scanline_irq_unit.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_scanline_irq_unit
// Cartridge bank mapper with scanline IRQ counter; one bus access per beat.
// ----------------------------------------------------------------------------
//  channel | handshake           | payload
//  --------+---------------------+-----------------------------------------
//  in      | in_valid/in_ready   | opcode, bus_address, data_in
//  out     | out_valid/out_ready | handled, target, mapped_offset,
//          |                     | mirroring, irq
//  cfg     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// Each access runs in steps: the beat edge decodes and updates registers, the
// bit-serial remainder unit reduces the bank number modulo the bank count, a
// finish step follows, and the output register loads. in_ready is high only
// in idle, so a new access waits until the result is loaded; a result held
// back by out_ready stalls the load. Reset initialises all control and mapper
// state; configuration writes are always accepted (cfg_ready high).
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_scanline_irq_unit (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [1:0]  opcode,
	input  wire  [15:0] bus_address,
	input  wire  [7:0]  data_in,
	output logic        out_valid,
	input  wire         out_ready,
	output logic        handled,
	output logic [1:0]  target,
	output logic [18:0] mapped_offset,
	output logic [1:0]  mirroring,
	output logic        irq,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [1:0]  cfg_index,
	input  wire  [8:0]  cfg_data
);

	// configuration
	logic [6:0] prg_count_q;
	logic [8:0] chr_count_q;
	logic       chr_ram_q;

	// mapper state
	logic [7:0] bank_sel_q;
	logic [7:0] bank_q [8];
	logic [1:0] mirror_q;
	logic [7:0] irq_latch_q;
	logic [7:0] irq_cnt_q;
	logic       irq_reload_q;
	logic       irq_en_q;
	logic       irq_pend_q;
	logic       prev_a12_q;

	// item in flight
	logic        handled_q;
	logic [1:0]  tgt_q;
	logic [12:0] low_q;

	// output register
	logic        out_valid_q;
	logic        out_handled_q;
	logic [1:0]  out_tgt_q;
	logic [18:0] out_off_q;
	logic [1:0]  out_mir_q;
	logic        out_irq_q;

	bmsirq_pkg::state_t    state_q, state_d;
	bmsirq_pkg::div_cmd_t  dcmd;
	bmsirq_pkg::div_stat_t dstat;

	logic       in_beat;
	logic       out_free;
	logic       load_out;
	logic       is_cpu;
	logic       is_ram_win;
	logic       is_rom_win;
	logic       is_chr_win;
	logic       claim;
	logic [1:0] tgt_d;
	logic [8:0] prg_cnt;
	logic [8:0] chr_cnt;
	logic [7:0] prg_last;
	logic [7:0] second_bank;
	logic [7:0] prg_raw;
	logic [7:0] chr_raw;
	logic [2:0] slot;
	logic [1:0] mir_cfg;
	logic [7:0] cnt_next;
	logic [18:0] off_d;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == bmsirq_pkg::ST_IDLE);
	assign in_beat   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// clamp bank counts: zero means one, saturate at the maximum
	always_comb begin
		prg_cnt = {2'b00, prg_count_q};
		if (prg_count_q == 7'd0) prg_cnt = 9'd1;
		else if ({2'b00, prg_count_q} > bmsirq_pkg::PRG_BANKS_MAX)
			prg_cnt = bmsirq_pkg::PRG_BANKS_MAX;
		chr_cnt = chr_count_q;
		if (chr_count_q == 9'd0) chr_cnt = 9'd1;
		else if (chr_count_q > bmsirq_pkg::CHR_BANKS_MAX)
			chr_cnt = bmsirq_pkg::CHR_BANKS_MAX;
	end

	// decode the access
	always_comb begin
		is_cpu     = (opcode == bmsirq_pkg::OP_CPU_RD) || (opcode == bmsirq_pkg::OP_CPU_WR);
		is_ram_win = is_cpu && (bus_address[15:13] == 3'b011);
		is_rom_win = is_cpu && bus_address[15];
		is_chr_win = !is_cpu && (bus_address[15:13] == 3'b000);
		claim = 1'b0;
		tgt_d = bmsirq_pkg::TGT_NONE;
		if (is_ram_win) begin
			claim = 1'b1;
			tgt_d = bmsirq_pkg::TGT_PRG_RAM;
		end else if (is_rom_win) begin
			claim = 1'b1;
			if (opcode == bmsirq_pkg::OP_CPU_RD) tgt_d = bmsirq_pkg::TGT_PRG_ROM;
		end else if (is_chr_win && (opcode == bmsirq_pkg::OP_PPU_RD || chr_ram_q)) begin
			claim = 1'b1;
			tgt_d = bmsirq_pkg::TGT_CHR;
		end
	end

	// program window bank; fixed banks are already below the count
	always_comb begin
		prg_last    = 8'(prg_cnt - 9'd1);
		second_bank = (prg_cnt > 9'd1) ? 8'(prg_cnt - 9'd2) : prg_last;
		case (bus_address[14:13])
			2'd0:    prg_raw = bank_sel_q[6] ? second_bank : bank_q[6];
			2'd1:    prg_raw = bank_q[7];
			2'd2:    prg_raw = bank_sel_q[6] ? bank_q[6] : second_bank;
			default: prg_raw = prg_last;
		endcase
	end

	// pattern window bank: flip the 4 KiB half when bank select bit 7 is set
	always_comb begin
		slot = bus_address[12:10] ^ {bank_sel_q[7], 2'b00};
		case (slot)
			3'd0:    chr_raw = {bank_q[0][7:1], 1'b0};
			3'd1:    chr_raw = {bank_q[0][7:1], 1'b1};
			3'd2:    chr_raw = {bank_q[1][7:1], 1'b0};
			3'd3:    chr_raw = {bank_q[1][7:1], 1'b1};
			3'd4:    chr_raw = bank_q[2];
			3'd5:    chr_raw = bank_q[3];
			3'd6:    chr_raw = bank_q[4];
			default: chr_raw = bank_q[5];
		endcase
	end

	// kick the remainder unit on every beat
	always_comb begin
		dcmd.start = in_beat;
		if (is_chr_win) begin
			dcmd.dividend = chr_raw;
			dcmd.divisor  = chr_cnt;
		end else begin
			dcmd.dividend = prg_raw;
			dcmd.divisor  = prg_cnt;
		end
	end

	bmsirq_mod u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (dcmd),
		.stat   (dstat)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= bmsirq_pkg::ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		load_out = 1'b0;
		unique case (state_q)
			bmsirq_pkg::ST_IDLE: begin
				if (in_beat) state_d = bmsirq_pkg::ST_DIV;
			end
			bmsirq_pkg::ST_DIV: begin
				if (dstat.done) state_d = bmsirq_pkg::ST_OUT;
			end
			bmsirq_pkg::ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = bmsirq_pkg::ST_IDLE;
				end
			end
			default: state_d = bmsirq_pkg::ST_IDLE;
		endcase
	end

	// hold the decoded item
	always_ff @(posedge clk) begin
		if (in_beat) begin
			handled_q <= claim;
			tgt_q     <= tgt_d;
			low_q     <= bus_address[12:0];
		end
	end

	// counter value after an A12 rise
	assign cnt_next = (irq_cnt_q == 8'd0 || irq_reload_q) ? irq_latch_q : irq_cnt_q - 8'd1;
	assign mir_cfg  = (cfg_data[1:0] == 2'd3) ? bmsirq_pkg::MIR_FOUR : cfg_data[1:0];

	// mapper and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_count_q  <= 7'd32;
			chr_count_q  <= 9'd128;
			chr_ram_q    <= 1'b0;
			bank_sel_q   <= '0;
			for (int i = 0; i < 8; i++) bank_q[i] <= '0;
			bank_q[7]    <= 8'd1;
			mirror_q     <= bmsirq_pkg::MIR_VERT;
			irq_latch_q  <= '0;
			irq_cnt_q    <= '0;
			irq_reload_q <= 1'b0;
			irq_en_q     <= 1'b0;
			irq_pend_q   <= 1'b0;
			prev_a12_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					bmsirq_pkg::CFG_PRG_COUNT: prg_count_q <= cfg_data[6:0];
					bmsirq_pkg::CFG_CHR_COUNT: chr_count_q <= cfg_data;
					bmsirq_pkg::CFG_CHR_RAM:   chr_ram_q   <= cfg_data[0];
					bmsirq_pkg::CFG_INIT_MIR:  mirror_q    <= mir_cfg;
					default: ;
				endcase
			end
			if (in_beat && opcode == bmsirq_pkg::OP_CPU_WR && bus_address[15]) begin
				case (bus_address[14:13])
					2'd0: begin
						if (!bus_address[0]) bank_sel_q <= data_in;
						else bank_q[bank_sel_q[2:0]] <= data_in;
					end
					2'd1: begin
						if (!bus_address[0] && mirror_q != bmsirq_pkg::MIR_FOUR)
							mirror_q <= data_in[0] ? bmsirq_pkg::MIR_HORZ : bmsirq_pkg::MIR_VERT;
					end
					2'd2: begin
						if (!bus_address[0]) irq_latch_q <= data_in;
						else irq_reload_q <= 1'b1;
					end
					default: begin
						if (!bus_address[0]) begin
							irq_en_q   <= 1'b0;
							irq_pend_q <= 1'b0;
						end else begin
							irq_en_q <= 1'b1;
						end
					end
				endcase
			end
			// watch A12 on pattern accesses only
			if (in_beat && is_chr_win) begin
				prev_a12_q <= bus_address[12];
				if (bus_address[12] && !prev_a12_q) begin
					irq_cnt_q    <= cnt_next;
					irq_reload_q <= 1'b0;
					if (cnt_next == 8'd0 && irq_en_q) irq_pend_q <= 1'b1;
				end
			end
		end
	end

	// assemble the offset from the reduced bank
	always_comb begin
		case (tgt_q)
			bmsirq_pkg::TGT_PRG_RAM: off_d = {6'd0, low_q};
			bmsirq_pkg::TGT_PRG_ROM: off_d = {dstat.rem[5:0], low_q};
			bmsirq_pkg::TGT_CHR:     off_d = {1'b0, dstat.rem, low_q[9:0]};
			default:                 off_d = '0;
		endcase
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_handled_q <= handled_q;
			out_tgt_q     <= tgt_q;
			out_off_q     <= off_d;
			out_mir_q     <= mirror_q;
			out_irq_q     <= irq_pend_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign handled       = out_handled_q;
	assign target        = out_tgt_q;
	assign mapped_offset = out_off_q;
	assign mirroring     = out_mir_q;
	assign irq           = out_irq_q;

	logic unused_busy;
	assign unused_busy = dstat.busy;

endmodule

`default_nettype wire

// ===== design/bmsirq_checker.sv =====
// ----------------------------------------------------------------------------
// bmsirq_checker
// Port-level assertions for the bank mapper, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module bmsirq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire        handled,
	input wire [1:0]  target,
	input wire [18:0] mapped_offset
);

	// one access at a time: busy right after a beat
	`BMSIRQ_ASSERT_NXT(a_busy_after_beat, clk, arst_n, in_valid && in_ready, !in_ready)

	// unclaimed accesses report no target and no offset
	`BMSIRQ_ASSERT_IMP(a_unclaimed_zero, clk, arst_n, out_valid && !handled, target == bmsirq_pkg::TGT_NONE && mapped_offset == 19'd0)

	// a memory target is always a claimed access
	`BMSIRQ_ASSERT_IMP(a_target_claimed, clk, arst_n, out_valid && target != bmsirq_pkg::TGT_NONE, handled)

	// a stalled result holds
	`BMSIRQ_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(mapped_offset))

endmodule

bind bank_mapper_with_scanline_irq_unit bmsirq_checker u_bmsirq_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.handled       (handled),
	.target        (target),
	.mapped_offset (mapped_offset)
);

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bank mapper: directed table, then random bursts
// of bus accesses checked against an in-bench model of banking and the IRQ.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;

	typedef struct packed {
		logic        handled;
		logic [1:0]  target;
		logic [18:0] mapped_offset;
		logic [1:0]  mirroring;
		logic        irq;
	} access_result_t;

	typedef struct {
		logic [1:0]  op;
		logic [15:0] addr;
		logic [7:0]  data;
		logic        has_known;
		access_result_t known;
	} stim_row_t;

	logic clk, arst_n;
	logic in_valid, in_ready;
	logic [1:0] opcode;
	logic [15:0] bus_address;
	logic [7:0] data_in;
	logic out_valid, out_ready;
	logic handled;
	logic [1:0] target;
	logic [18:0] mapped_offset;
	logic [1:0] mirroring;
	logic irq;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [8:0] cfg_data;

	bank_mapper_with_scanline_irq_unit uut (.*);

	// mirror of the mapper configuration and state
	int unsigned prg_count_reg, chr_count_reg, chr_ram_reg;
	logic [7:0] sel_reg;
	logic [7:0] banks [8];
	logic [1:0] mir_now;
	logic [7:0] latch_val, scan_count;
	logic reload_req, irq_on, irq_flag, last_a12;

	access_result_t pending_results [$];
	int errors;
	int bursting;

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic int unsigned bank_total(int unsigned n, int unsigned top);
		if (n == 0) return 1;
		if (n > top) return top;
		return n;
	endfunction

	function automatic logic [18:0] prg_map(logic [15:0] a);
		int unsigned cnt, last, second, b6, b7, bk;
		cnt = bank_total(prg_count_reg, 64);
		last = cnt - 1;
		second = (cnt > 1) ? cnt - 2 : last;
		b6 = banks[6] % cnt;
		b7 = banks[7] % cnt;
		if (a < 16'hA000) bk = sel_reg[6] ? second : b6;
		else if (a < 16'hC000) bk = b7;
		else if (a < 16'hE000) bk = sel_reg[6] ? b6 : second;
		else bk = last;
		return 19'(bk * 32'h2000 + (a & 16'h1FFF));
	endfunction

	function automatic logic [18:0] chr_map(logic [15:0] a);
		int unsigned cnt, slot, r0, r1, lo, hi;
		int unsigned win [8];
		cnt = bank_total(chr_count_reg, 256);
		slot = (a >> 10) & 7;
		r0 = banks[0] & 8'hFE;
		r1 = banks[1] & 8'hFE;
		lo = sel_reg[7] ? 4 : 0;
		hi = lo ^ 4;
		win[lo] = r0;
		win[lo + 1] = (r0 + 1) & 8'hFF;
		win[lo + 2] = r1;
		win[lo + 3] = (r1 + 1) & 8'hFF;
		win[hi] = banks[2];
		win[hi + 1] = banks[3];
		win[hi + 2] = banks[4];
		win[hi + 3] = banks[5];
		return 19'((win[slot] % cnt) * 32'h400 + (a & 16'h3FF));
	endfunction

	// advance the mirror by one access and return its result
	function automatic access_result_t map_access(logic [1:0] op, logic [15:0] a,
			logic [7:0] d);
		access_result_t r;
		r = '0;
		if (op == bmsirq_pkg::OP_CPU_RD || op == bmsirq_pkg::OP_CPU_WR) begin
			if (a >= 16'h6000 && a <= 16'h7FFF) begin
				r.handled = 1'b1;
				r.target = bmsirq_pkg::TGT_PRG_RAM;
				r.mapped_offset = 19'(a - 16'h6000);
			end else if (a >= 16'h8000) begin
				r.handled = 1'b1;
				if (op == bmsirq_pkg::OP_CPU_RD) begin
					r.target = bmsirq_pkg::TGT_PRG_ROM;
					r.mapped_offset = prg_map(a);
				end else if (a <= 16'h9FFF) begin
					if (!a[0]) sel_reg = d;
					else banks[sel_reg[2:0]] = d;
				end else if (a <= 16'hBFFF) begin
					if (!a[0] && mir_now != bmsirq_pkg::MIR_FOUR)
						mir_now = d[0] ? bmsirq_pkg::MIR_HORZ : bmsirq_pkg::MIR_VERT;
				end else if (a <= 16'hDFFF) begin
					if (!a[0]) latch_val = d;
					else reload_req = 1'b1;
				end else begin
					if (!a[0]) begin
						irq_on = 1'b0;
						irq_flag = 1'b0;
					end else irq_on = 1'b1;
				end
			end
		end else if (a <= 16'h1FFF) begin
			// clock the scanline counter on a rising A12
			if (a[12] && !last_a12) begin
				if (scan_count == 8'd0 || reload_req) scan_count = latch_val;
				else scan_count = scan_count - 8'd1;
				if (scan_count == 8'd0 && irq_on) irq_flag = 1'b1;
				reload_req = 1'b0;
			end
			last_a12 = a[12];
			if (op == bmsirq_pkg::OP_PPU_RD || chr_ram_reg != 0) begin
				r.handled = 1'b1;
				r.target = bmsirq_pkg::TGT_CHR;
				r.mapped_offset = chr_map(a);
			end
		end
		r.mirroring = mir_now;
		r.irq = irq_flag;
		return r;
	endfunction

	task automatic write_cfg(logic [1:0] idx, logic [8:0] val);
		@(negedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			bmsirq_pkg::CFG_PRG_COUNT: prg_count_reg = val[6:0];
			bmsirq_pkg::CFG_CHR_COUNT: chr_count_reg = val;
			bmsirq_pkg::CFG_CHR_RAM: chr_ram_reg = val[0];
			default: begin
				mir_now = (val[1:0] == 2'd3) ? bmsirq_pkg::MIR_FOUR : val[1:0];
			end
		endcase
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	// drain all expected beats before touching configuration
	task automatic wait_idle();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (15) @(posedge clk);
	endtask

	// send one access; bursts with random gaps between them
	task automatic send_access(logic [1:0] op, logic [15:0] a, logic [7:0] d);
		// step to a fresh falling edge so in_valid changes once per edge
		@(negedge clk);
		if (bursting == 0) begin
			repeat ($urandom_range(0, 6)) @(negedge clk);
			bursting = $urandom_range(1, 12);
		end
		bursting--;
		in_valid <= 1;
		opcode <= op;
		bus_address <= a;
		data_in <= d;
		do @(posedge clk); while (!in_ready);
		pending_results.push_back(map_access(op, a, d));
		@(negedge clk);
		in_valid <= 0;
	endtask

	// receiver stalls in its own pattern: long open stretches, then jitter
	always @(negedge clk) begin
		if (!arst_n) out_ready <= 0;
		else if (($time / 20000) % 3 == 0) out_ready <= 1;
		else out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		access_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (handled !== want.handled) begin
					$error("handled exp %0d got %0d", want.handled, handled);
					errors++;
				end
				if (target !== want.target) begin
					$error("target exp %0d got %0d", want.target, target);
					errors++;
				end
				if (mapped_offset !== want.mapped_offset) begin
					$error("mapped_offset exp %0h got %0h", want.mapped_offset,
						mapped_offset);
					errors++;
				end
				if (mirroring !== want.mirroring) begin
					$error("mirroring exp %0d got %0d", want.mirroring, mirroring);
					errors++;
				end
				if (irq !== want.irq) begin
					$error("irq exp %0d got %0d", want.irq, irq);
					errors++;
				end
			end
		end
	end

	task automatic random_phase(int n);
		int k, kind;
		logic [1:0] op;
		logic [15:0] a;
		for (k = 0; k < n; k++) begin
			kind = $urandom_range(0, 99);
			if (kind < 30) begin
				// register program: random writes to the select, bank value or other reg pairs
				op = bmsirq_pkg::OP_CPU_WR;
				a = 16'h8000 | 16'($urandom_range(0, 3) << 13) | 16'($urandom_range(0, 1));
				a = a | (16'($urandom) & 16'h1FFE);
			end else if (kind < 60) begin
				// scanline-like fetches toggling A12
				op = $urandom_range(0, 1) ? bmsirq_pkg::OP_PPU_RD : bmsirq_pkg::OP_PPU_WR;
				a = 16'($urandom) & 16'h1FFF;
				if ($urandom_range(0, 1)) a[12] = ~last_a12;
			end else if (kind < 85) begin
				op = bmsirq_pkg::OP_CPU_RD;
				a = 16'h6000 + 16'($urandom_range(0, 16'h9FFF));
			end else begin
				op = 2'($urandom);
				a = 16'($urandom);
			end
			send_access(op, a, 8'($urandom));
			if (k == n / 2) wait_idle();
		end
	endtask

	stim_row_t directed [] = '{
		'{bmsirq_pkg::OP_CPU_RD, 16'h8000, 8'h00, 1,
			'{1, bmsirq_pkg::TGT_PRG_ROM, 19'h00000, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_CPU_RD, 16'hA000, 8'h00, 1,
			'{1, bmsirq_pkg::TGT_PRG_ROM, 19'h02000, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_CPU_RD, 16'hFFFF, 8'h00, 1,
			'{1, bmsirq_pkg::TGT_PRG_ROM, 19'h3FFFF, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_CPU_RD, 16'h5FFF, 8'hFF, 1,
			'{0, bmsirq_pkg::TGT_NONE, 19'h0, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_CPU_WR, 16'h6000, 8'hFF, 1,
			'{1, bmsirq_pkg::TGT_PRG_RAM, 19'h0, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_CPU_RD, 16'h7FFF, 8'h00, 1,
			'{1, bmsirq_pkg::TGT_PRG_RAM, 19'h1FFF, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_PPU_RD, 16'h2000, 8'h00, 1,
			'{0, bmsirq_pkg::TGT_NONE, 19'h0, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_PPU_WR, 16'h0000, 8'h00, 1,
			'{0, bmsirq_pkg::TGT_NONE, 19'h0, bmsirq_pkg::MIR_VERT, 0}},
		'{bmsirq_pkg::OP_CPU_WR, 16'hA000, 8'h01, 1,
			'{1, bmsirq_pkg::TGT_NONE, 19'h0, bmsirq_pkg::MIR_HORZ, 0}},
		'{bmsirq_pkg::OP_CPU_WR, 16'h8000, 8'hC6, 0, '0},
		'{bmsirq_pkg::OP_CPU_WR, 16'h8001, 8'hFF, 0, '0},
		'{bmsirq_pkg::OP_CPU_RD, 16'h8000, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_CPU_RD, 16'hC123, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_CPU_WR, 16'hC000, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_CPU_WR, 16'hC001, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_CPU_WR, 16'hE001, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_PPU_RD, 16'h1FFF, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_PPU_RD, 16'h0FFF, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_PPU_RD, 16'h1000, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_CPU_WR, 16'hE000, 8'h00, 0, '0},
		'{bmsirq_pkg::OP_PPU_RD, 16'h0400, 8'h00, 0, '0}
	};

	initial begin
		stim_row_t row;
		int i;
		errors = 0;
		bursting = 0;
		in_valid = 0;
		opcode = bmsirq_pkg::OP_CPU_RD;
		bus_address = 0;
		data_in = 0;
		cfg_valid = 0;
		cfg_index = bmsirq_pkg::CFG_PRG_COUNT;
		cfg_data = 0;
		prg_count_reg = 32;
		chr_count_reg = 128;
		chr_ram_reg = 0;
		sel_reg = 0;
		foreach (banks[j]) banks[j] = 0;
		banks[7] = 1;
		mir_now = bmsirq_pkg::MIR_VERT;
		latch_val = 0;
		scan_count = 0;
		reload_req = 0;
		irq_on = 0;
		irq_flag = 0;
		last_a12 = 0;
		arst_n = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		for (i = 0; i < directed.size(); i++) begin
			row = directed[i];
			if (row.has_known) begin
				// typed results must agree with the model's queued result
				send_access(row.op, row.addr, row.data);
				if (pending_results[$] !== row.known) begin
					$error("table row %0d: typed result disagrees", i);
					errors++;
				end
			end else send_access(row.op, row.addr, row.data);
		end
		wait_idle();

		// walk bank-count extremes, pattern RAM and mirroring modes
		write_cfg(bmsirq_pkg::CFG_PRG_COUNT, 9'd1);
		write_cfg(bmsirq_pkg::CFG_CHR_COUNT, 9'd1);
		write_cfg(bmsirq_pkg::CFG_CHR_RAM, 9'd1);
		write_cfg(bmsirq_pkg::CFG_INIT_MIR, 9'd2);
		random_phase(300);
		wait_idle();
		write_cfg(bmsirq_pkg::CFG_PRG_COUNT, 9'd64);
		write_cfg(bmsirq_pkg::CFG_CHR_COUNT, 9'd256);
		write_cfg(bmsirq_pkg::CFG_CHR_RAM, 9'd0);
		write_cfg(bmsirq_pkg::CFG_INIT_MIR, 9'd1);
		random_phase(300);
		wait_idle();
		write_cfg(bmsirq_pkg::CFG_PRG_COUNT, 9'd0);
		write_cfg(bmsirq_pkg::CFG_CHR_COUNT, 9'd0);
		write_cfg(bmsirq_pkg::CFG_INIT_MIR, 9'd3);
		random_phase(250);
		wait_idle();
		write_cfg(bmsirq_pkg::CFG_PRG_COUNT, 9'd127);
		write_cfg(bmsirq_pkg::CFG_CHR_COUNT, 9'd511);
		write_cfg(bmsirq_pkg::CFG_CHR_RAM, 9'd1);
		write_cfg(bmsirq_pkg::CFG_INIT_MIR, 9'd0);
		random_phase(250);
		wait_idle();
		for (i = 0; i < 3; i++) begin
			write_cfg(bmsirq_pkg::CFG_PRG_COUNT, 9'($urandom_range(1, 127)));
			write_cfg(bmsirq_pkg::CFG_CHR_COUNT, 9'($urandom_range(1, 511)));
			write_cfg(bmsirq_pkg::CFG_CHR_RAM, 9'($urandom_range(0, 1)));
			write_cfg(bmsirq_pkg::CFG_INIT_MIR, 9'($urandom_range(0, 3)));
			random_phase(250);
			wait_idle();
		end

		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

`default_nettype wire
